// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared codes, widths and types of the motion-to-scroll unit.
// ----------------------------------------------------------------------------
package msc_pkg;

   localparam int MotionWidth = 16;
   localparam int MagWidth    = MotionWidth + 1;   // magnitude 0..32768
   localparam int ProdWidth   = 28;                // 32768 * 4095 fits
   localparam int ThrWidth    = 15;
   localparam int TanWidth    = 12;
   localparam int CsrAddrWidth = 2;

   localparam logic [ProdWidth-1:0] PerMille = ProdWidth'(1000);

   // input kinds (req_tuser)
   localparam logic [1:0] KIND_X     = 2'd0;
   localparam logic [1:0] KIND_Y     = 2'd1;
   localparam logic [1:0] KIND_OTHER = 2'd2;

   // result actions (rsp_tuser)
   localparam logic [1:0] ACT_DROP   = 2'd0;
   localparam logic [1:0] ACT_PASS   = 2'd1;
   localparam logic [1:0] ACT_WHEEL  = 2'd2;
   localparam logic [1:0] ACT_HWHEEL = 2'd3;

   // scroll step codes
   localparam logic [1:0] STEP_ZERO = 2'b00;
   localparam logic [1:0] STEP_POS  = 2'b01;
   localparam logic [1:0] STEP_NEG  = 2'b11;

   // register indexes
   localparam logic [CsrAddrWidth-1:0] REG_STEP_THRESHOLD = 2'd0;
   localparam logic [CsrAddrWidth-1:0] REG_TAN_LIMIT      = 2'd1;
   localparam logic [CsrAddrWidth-1:0] REG_INVERT_H       = 2'd2;
   localparam logic [CsrAddrWidth-1:0] REG_INVERT_V       = 2'd3;

   localparam logic [ThrWidth-1:0] THRESHOLD_RESET = ThrWidth'(8);
   localparam logic [TanWidth-1:0] TAN_RESET       = TanWidth'(700);

   // classifier verdict
   typedef struct packed {
      logic vertical;     // up or down
      logic horizontal;   // right or left
      logic positive;     // up for vertical, right for horizontal
   } dir_type;

endpackage

// ===== rtl/core/msc_classify.sv =====
// ----------------------------------------------------------------------------
// msc_classify
// Direction decision from registered axis products.
// ----------------------------------------------------------------------------
module msc_classify (
   input  logic [msc_pkg::ProdWidth-1:0] ax_k,      // |x| * 1000
   input  logic [msc_pkg::ProdWidth-1:0] ay_k,      // |y| * 1000
   input  logic [msc_pkg::ProdWidth-1:0] ax_tan,    // |x| * tan
   input  logic [msc_pkg::ProdWidth-1:0] ay_tan,    // |y| * tan
   input  logic                          ax_zero,
   input  logic                          ay_zero,
   input  logic                          x_neg,
   input  logic                          y_neg,
   output msc_pkg::dir_type              dir
);
   import msc_pkg::*;

   logic still;
   logic vert_ok;
   logic horiz_ok;

   assign still    = ax_zero && ay_zero;
   assign vert_ok  = ax_k <= ay_tan;
   assign horiz_ok = ay_k <= ax_tan;

   // vertical wins the tie
   always_comb begin
      dir = '0;
      priority if (still) begin
         dir = '0;
      end else if (vert_ok) begin
         dir.vertical = 1'b1;
         dir.positive = y_neg;
      end else if (horiz_ok) begin
         dir.horizontal = 1'b1;
         dir.positive   = !x_neg && !ax_zero;
      end else begin
         dir = '0;
      end
   end

endmodule

// ===== rtl/core/motion_to_axis_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// motion_to_axis_scroll_unit
// Converts relative pointer motion into vertical and horizontal wheel steps.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction, in order,
// and a new input is taken every cycle while the result side keeps up; each
// passes the input register, the product register and the result register.
// An X transaction latches its motion and returns a drop; a Y
// transaction pairs with the latched X, is classified by comparing
// |minor| * 1000 against |major| * tan_limit_per_mille (vertical checked
// first), and feeds the vertical or horizontal accumulator. When the touched
// accumulator reaches step_threshold one wheel (action 2) or hwheel
// (action 3) step of +1/-1 comes out and that accumulator clears; any other
// Y result is a drop. Up and right are +1 unless the matching invert bit is
// set. Other kinds come back as pass. The latch clears after every Y.
// Registers must be written through csr_we/csr_addr/csr_wdata only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module motion_to_axis_scroll_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic                              csr_we,
   input  logic [msc_pkg::CsrAddrWidth-1:0]  csr_addr,
   input  logic [msc_pkg::ThrWidth-1:0]      csr_wdata,
   // motion input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [15:0] motion (signed)
   input  logic [1:0]  req_tuser,     // [1:0] kind
   // scroll result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // [1:0] scroll_step (signed), [7:2] zero
   output logic [1:0]  rsp_tuser      // [1:0] action
);
   import msc_pkg::*;

   // ---------------- configuration ----------------
   logic [ThrWidth-1:0] thr_ff;
   logic [TanWidth-1:0] tan_ff;
   logic                inv_h_ff;
   logic                inv_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RESET;
         tan_ff   <= TAN_RESET;
         inv_h_ff <= 1'b0;
         inv_v_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_STEP_THRESHOLD: thr_ff   <= csr_wdata;
            REG_TAN_LIMIT:      tan_ff   <= csr_wdata[TanWidth-1:0];
            REG_INVERT_H:       inv_h_ff <= csr_wdata[0];
            REG_INVERT_V:       inv_v_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // each stage moves when the one ahead is empty or moving
   logic s1_v_ff, s2_v_ff, out_v_ff;
   logic out_rdy, s2_rdy, s1_rdy;
   logic acc_in, s1_mv, s2_mv;

   assign out_rdy    = !out_v_ff || rsp_tready;
   assign s2_rdy     = !s2_v_ff  || out_rdy;
   assign s1_rdy     = !s1_v_ff  || s2_rdy;
   assign req_tready = s1_rdy;
   assign acc_in     = req_tvalid && s1_rdy;
   assign s1_mv      = s1_v_ff && s2_rdy;
   assign s2_mv      = s2_v_ff && out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_rdy)  s1_v_ff  <= req_tvalid;
         if (s2_rdy)  s2_v_ff  <= s1_v_ff;
         if (out_rdy) out_v_ff <= s2_v_ff;
      end
   end

   // ---------------- X latch, kept at the accept edge ----------------
   logic [MotionWidth-1:0] latch_x_ff, latch_x_in;

   always_comb begin
      latch_x_in = latch_x_ff;
      if (acc_in) begin
         if (req_tuser == KIND_X)      latch_x_in = req_tdata;
         else if (req_tuser == KIND_Y) latch_x_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) latch_x_ff <= '0;
      else       latch_x_ff <= latch_x_in;
   end

   // ---------------- stage 1: captured transaction ----------------
   logic [1:0]             s1_kind_ff;
   logic [MotionWidth-1:0] s1_x_ff, s1_y_ff;

   always_ff @(posedge clock) begin
      if (acc_in) begin
         s1_kind_ff <= req_tuser;
         s1_x_ff    <= latch_x_ff;   // X as seen before this transaction
         s1_y_ff    <= req_tdata;
      end
   end

   // magnitudes and the four products
   logic [MagWidth-1:0]  ax, ay;
   logic [ProdWidth-1:0] ax_k_in, ay_k_in, ax_tan_in, ay_tan_in;

   assign ax = s1_x_ff[MotionWidth-1] ? ({1'b0, ~s1_x_ff} + MagWidth'(1))
                                      : {1'b0, s1_x_ff};
   assign ay = s1_y_ff[MotionWidth-1] ? ({1'b0, ~s1_y_ff} + MagWidth'(1))
                                      : {1'b0, s1_y_ff};
   assign ax_k_in   = ProdWidth'(ax) * PerMille;
   assign ay_k_in   = ProdWidth'(ay) * PerMille;
   assign ax_tan_in = ProdWidth'(ax) * ProdWidth'(tan_ff);
   assign ay_tan_in = ProdWidth'(ay) * ProdWidth'(tan_ff);

   // ---------------- stage 2: products ----------------
   logic [1:0]           s2_kind_ff;
   logic [MagWidth-1:0]  s2_ax_ff, s2_ay_ff;
   logic                 s2_xneg_ff, s2_yneg_ff;
   logic [ProdWidth-1:0] ax_k_ff, ay_k_ff, ax_tan_ff, ay_tan_ff;

   always_ff @(posedge clock) begin
      if (s1_mv) begin
         s2_kind_ff <= s1_kind_ff;
         s2_ax_ff   <= ax;
         s2_ay_ff   <= ay;
         s2_xneg_ff <= s1_x_ff[MotionWidth-1];
         s2_yneg_ff <= s1_y_ff[MotionWidth-1];
         ax_k_ff    <= ax_k_in;
         ay_k_ff    <= ay_k_in;
         ax_tan_ff  <= ax_tan_in;
         ay_tan_ff  <= ay_tan_in;
      end
   end

   dir_type dir;

   msc_classify u_classify (
      .ax_k    (ax_k_ff),
      .ay_k    (ay_k_ff),
      .ax_tan  (ax_tan_ff),
      .ay_tan  (ay_tan_ff),
      .ax_zero (s2_ax_ff == '0),
      .ay_zero (s2_ay_ff == '0),
      .x_neg   (s2_xneg_ff),
      .y_neg   (s2_yneg_ff),
      .dir     (dir)
   );

   // ---------------- accumulators and result ----------------
   logic [MotionWidth-1:0] v_sum_ff, v_sum_in, h_sum_ff, h_sum_in;
   logic [MotionWidth-1:0] v_add, h_add;
   logic [1:0]             act_ff, act_in, step_ff, step_in;
   logic                   pos_v, pos_h;

   // sums stay below the threshold before an add, so 16 bits never wrap
   assign v_add = v_sum_ff + s2_ay_ff[MotionWidth-1:0];
   assign h_add = h_sum_ff + s2_ax_ff[MotionWidth-1:0];
   assign pos_v = dir.positive ^ inv_v_ff;
   assign pos_h = dir.positive ^ inv_h_ff;

   always_comb begin
      v_sum_in = v_sum_ff;
      h_sum_in = h_sum_ff;
      act_in   = ACT_PASS;
      step_in  = STEP_ZERO;
      if (s2_kind_ff == KIND_X) begin
         act_in = ACT_DROP;
      end else if (s2_kind_ff == KIND_Y) begin
         act_in = ACT_DROP;
         priority if (dir.vertical) begin
            h_sum_in = '0;
            v_sum_in = v_add;
            if (v_add >= MotionWidth'(thr_ff)) begin
               v_sum_in = '0;
               act_in   = ACT_WHEEL;
               step_in  = pos_v ? STEP_POS : STEP_NEG;
            end
         end else if (dir.horizontal) begin
            v_sum_in = '0;
            h_sum_in = h_add;
            if (h_add >= MotionWidth'(thr_ff)) begin
               h_sum_in = '0;
               act_in   = ACT_HWHEEL;
               step_in  = pos_h ? STEP_POS : STEP_NEG;
            end
         end else begin
            // diagonal or no motion
            v_sum_in = '0;
            h_sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_sum_ff <= '0;
         h_sum_ff <= '0;
      end else if (s2_mv) begin
         v_sum_ff <= v_sum_in;
         h_sum_ff <= h_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_mv) begin
         act_ff  <= act_in;
         step_ff <= step_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = act_ff;
   assign rsp_tdata  = {6'b0, step_ff};

endmodule

// ===== rtl/core/msc_checker.sv =====
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks of the motion-to-scroll unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [7:0]                        rsp_tdata,
   input logic [1:0]                        rsp_tuser
);
   import msc_pkg::*;

   // a stalled result transaction holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // drop and pass carry no step
   `ASSERT_CLK(a_idle_step, clock, reset, rsp_tvalid && (rsp_tuser == ACT_DROP || rsp_tuser == ACT_PASS) |-> rsp_tdata[1:0] == STEP_ZERO, "non-wheel result with a step")

   // wheel actions always step by one
   `ASSERT_CLK(a_wheel_step, clock, reset, rsp_tvalid && (rsp_tuser == ACT_WHEEL || rsp_tuser == ACT_HWHEEL) |-> rsp_tdata[1:0] == STEP_POS || rsp_tdata[1:0] == STEP_NEG, "wheel result without a unit step")

   // pad bits of the result stay clear
   `ASSERT_CLK(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[7:2] == 6'b0, "result pad bits set")

   // reset empties the pipeline
   `ASSERT_CLK_NR(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

bind motion_to_axis_scroll_unit msc_checker u_msc_checker (.*);
